// File: rtl/core/lge_pkg.sv
// ----------------------------------------------------------------------------
// Life grid engine package
// Shared sizes, opcodes, state codes and interface types of the life grid
// generation engine.
// ----------------------------------------------------------------------------
package lge_pkg;

    localparam int GRID_SIZE = 16;
    localparam int ROW_AW    = $clog2(GRID_SIZE);
    localparam int CNT_W     = $clog2(GRID_SIZE + 2);
    localparam int OPCODE_W  = 2;
    localparam int INDEX_W   = 4;
    localparam int CELLS_W   = 16;
    localparam int NEIGH_W   = 4;

    localparam logic [OPCODE_W-1:0] OP_WRITE = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_STEP  = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_READ  = 2'd2;

    localparam logic [NEIGH_W-1:0] BIRTH_COUNT   = 4'd3;
    localparam logic [NEIGH_W-1:0] SURVIVE_COUNT = 4'd2;

    localparam logic [CNT_W-1:0] CNT_ROWS = CNT_W'(GRID_SIZE);
    localparam logic [CNT_W-1:0] CNT_LAG  = CNT_W'(2);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(GRID_SIZE + 1);

    typedef logic [GRID_SIZE-1:0] t_row;
    typedef logic [ROW_AW-1:0]    t_addr;

    typedef struct packed {
        logic  wr_en;
        t_addr wr_addr;
        t_row  wr_data;
        logic  rd_en;
        t_addr rd_addr;
    } t_mem_req;

    typedef enum logic [1:0] {
        S_IDLE,
        S_READ,
        S_STEP
    } t_state;

endpackage

// File: rtl/core/lge_grid_mem.sv
// ----------------------------------------------------------------------------
// Life grid row memory
// One row word per entry, one write and one registered read port. Per-row
// valid bits make every row read as all dead until it is first written.
// ----------------------------------------------------------------------------
module lge_grid_mem import lge_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_mem_req i_req,
    output t_row     o_rd_data
);

    t_row                 r_mem [GRID_SIZE];
    logic [GRID_SIZE-1:0] r_vld;
    t_row                 r_rd_data;
    logic                 r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr] <= i_req.wr_data;
        end
        if (i_req.rd_en) begin
            r_rd_data <= r_mem[i_req.rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_req.wr_en) begin
                r_vld[i_req.wr_addr] <= 1'b1;
            end
            if (i_req.rd_en) begin
                r_rd_vld <= r_vld[i_req.rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

// File: rtl/core/lge_row_rule.sv
// ----------------------------------------------------------------------------
// Life row rule
// Computes the next generation of one row from the row above, the row itself
// and the row below, with cells beyond the edge counted as dead.
// ----------------------------------------------------------------------------
module lge_row_rule import lge_pkg::*; (
    input  t_row i_above,
    input  t_row i_here,
    input  t_row i_below,
    output t_row o_fresh
);

    logic [GRID_SIZE+1:0] w_a;
    logic [GRID_SIZE+1:0] w_h;
    logic [GRID_SIZE+1:0] w_b;
    logic [NEIGH_W-1:0]   w_cnt [GRID_SIZE];

    assign w_a = {1'b0, i_above, 1'b0};
    assign w_h = {1'b0, i_here, 1'b0};
    assign w_b = {1'b0, i_below, 1'b0};

    always_comb begin
        for (int c = 0; c < GRID_SIZE; c++) begin
            w_cnt[c] = NEIGH_W'(w_a[c]) + NEIGH_W'(w_a[c+1]) + NEIGH_W'(w_a[c+2])
                     + NEIGH_W'(w_h[c]) + NEIGH_W'(w_h[c+2])
                     + NEIGH_W'(w_b[c]) + NEIGH_W'(w_b[c+1]) + NEIGH_W'(w_b[c+2]);
            o_fresh[c] = (w_cnt[c] == BIRTH_COUNT)
                       || (i_here[c] && (w_cnt[c] == SURVIVE_COUNT));
        end
    end

endmodule

// File: rtl/core/life_grid_generation_engine.sv
// ----------------------------------------------------------------------------
// Life grid generation engine
// Holds a square grid of cells and loads, reads or advances it by one
// generation of the B3/S23 rule, one transfer per operation.
// ----------------------------------------------------------------------------
// A write or an unused opcode finishes in the cycle it is taken, a read in
// the cycle after. A generation step sweeps the rows through the single read
// port of the row memory and writes each new row back once the row below it
// has come out of that registered port. The grid reads as all dead after
// reset at once, with no clearing pass. One operation is in progress at a
// time; the result waits in an output register and the next transfer is
// taken as soon as that register is free or drains.
module life_grid_generation_engine import lge_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_stall,
    input  logic [OPCODE_W-1:0] i_opcode,
    input  logic [INDEX_W-1:0]  i_row_index,
    input  logic [CELLS_W-1:0]  i_row_cells,
    output logic                o_valid,
    input  logic                i_stall,
    output logic [CELLS_W-1:0]  o_read_cells,
    output logic                o_op_done
);

    t_state             r_state;
    t_state             n_state;
    logic [CNT_W-1:0]   r_cnt;
    t_row               r_above;
    t_row               r_here;
    logic               r_rd_ok;
    logic               r_out_valid;
    logic [CELLS_W-1:0] r_read_cells;
    logic               r_op_done;

    t_mem_req           w_req;
    t_row               w_rd_data;
    t_row               w_below;
    t_row               w_fresh;
    logic               w_accept;
    logic               w_in_range;
    logic               w_out_load;
    logic [CELLS_W-1:0] n_read_cells;
    logic               n_op_done;

    assign o_stall    = (r_state != S_IDLE) || (r_out_valid && i_stall);
    assign w_accept   = i_valid && !o_stall;
    assign w_in_range = (32'(i_row_index) < GRID_SIZE);

    lge_grid_mem u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (w_req),
        .o_rd_data (w_rd_data)
    );

    lge_row_rule u_rule (
        .i_above (r_above),
        .i_here  (r_here),
        .i_below (w_below),
        .o_fresh (w_fresh)
    );

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_opcode)
                        OP_READ: n_state = S_READ;
                        OP_STEP: n_state = S_STEP;
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_READ: n_state = S_IDLE;
            S_STEP: begin
                if (r_cnt == CNT_LAST) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        w_req        = '0;
        w_out_load   = 1'b0;
        n_read_cells = '0;
        n_op_done    = 1'b0;
        w_below      = '0;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (i_opcode)
                        OP_WRITE: begin
                            w_req.wr_en   = w_in_range;
                            w_req.wr_addr = ROW_AW'(i_row_index);
                            w_req.wr_data = GRID_SIZE'(i_row_cells);
                            w_out_load    = 1'b1;
                            n_op_done     = 1'b1;
                        end
                        OP_READ: begin
                            w_req.rd_en   = 1'b1;
                            w_req.rd_addr = ROW_AW'(i_row_index);
                        end
                        OP_STEP: begin
                            w_out_load = 1'b0;
                        end
                        default: begin
                            w_out_load = 1'b1;
                        end
                    endcase
                end
            end
            S_READ: begin
                w_out_load   = 1'b1;
                n_op_done    = 1'b1;
                n_read_cells = r_rd_ok ? CELLS_W'(w_rd_data) : '0;
            end
            S_STEP: begin
                w_req.rd_en   = (r_cnt < CNT_ROWS);
                w_req.rd_addr = ROW_AW'(r_cnt);
                w_below       = ((r_cnt != '0) && (r_cnt <= CNT_ROWS)) ? w_rd_data : '0;
                w_req.wr_en   = (r_cnt >= CNT_LAG);
                w_req.wr_addr = ROW_AW'(r_cnt - CNT_LAG);
                w_req.wr_data = w_fresh;
                if (r_cnt == CNT_LAST) begin
                    w_out_load = 1'b1;
                    n_op_done  = 1'b1;
                end
            end
            default: begin
                w_out_load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == S_STEP) begin
                r_cnt <= r_cnt + CNT_W'(1);
            end else begin
                r_cnt <= '0;
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rd_ok <= w_in_range;
        end
        if (r_state == S_STEP) begin
            r_above <= r_here;
            r_here  <= w_below;
        end
        if (w_out_load) begin
            r_read_cells <= n_read_cells;
            r_op_done    <= n_op_done;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_read_cells = r_read_cells;
    assign o_op_done    = r_op_done;

    a_no_same_row_access: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_req.wr_en && w_req.rd_en) |-> (w_req.wr_addr != w_req.rd_addr))
        else $error("row memory read and write hit the same row");

    a_result_not_lost: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_out_load |-> (!r_out_valid || !i_stall))
        else $error("result loaded over an undelivered result");

    a_step_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_STEP) && (r_cnt == '0))
        |-> ##(GRID_SIZE + 1) ((r_state == S_STEP) && (r_cnt == CNT_LAST)))
        else $error("generation sweep has the wrong length");

    a_step_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_STEP) && (r_cnt == CNT_LAST)) |=> (o_valid && (r_state == S_IDLE)))
        else $error("generation sweep did not deliver its result");

endmodule
